// ----- hdl/accumulator_vm_execute_unit_macros.svh -----
// Assertion macros for the accumulator machine execute unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ACCUMULATOR_VM_EXECUTE_UNIT_MACROS_SVH
`define ACCUMULATOR_VM_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTH
`define AVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("execute unit assertion failed");
`define AVM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("execute unit forbidden condition seen");
`else
`define AVM_ASSERT(lbl, prop)
`define AVM_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- hdl/avm_pkg.sv -----
`default_nettype none
package avm_pkg;

  localparam int MEM_DEPTH = 64;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int LEN_W     = 7;
  localparam int DATA_W    = 64;
  localparam int ARG_W     = 32;
  localparam int HALF_W    = DATA_W / 2;
  localparam int CNT_W     = 7;

  localparam logic [1:0] CMD_EXEC   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_UNK  = 2'd3;

  localparam logic [4:0] OP_CLEAR     = 5'd0;
  localparam logic [4:0] OP_AT        = 5'd1;
  localparam logic [4:0] OP_SET       = 5'd2;
  localparam logic [4:0] OP_INSERT    = 5'd3;
  localparam logic [4:0] OP_ERASE     = 5'd4;
  localparam logic [4:0] OP_ADDCONST  = 5'd5;
  localparam logic [4:0] OP_SUBCONST  = 5'd6;
  localparam logic [4:0] OP_MULCONST  = 5'd7;
  localparam logic [4:0] OP_DIVCONST  = 5'd8;
  localparam logic [4:0] OP_ADDMEM    = 5'd9;
  localparam logic [4:0] OP_SUBMEM    = 5'd10;
  localparam logic [4:0] OP_MULMEM    = 5'd11;
  localparam logic [4:0] OP_DIVMEM    = 5'd12;
  localparam logic [4:0] OP_JUMPREL   = 5'd13;
  localparam logic [4:0] OP_JUMPZERO  = 5'd14;
  localparam logic [4:0] OP_JUMPNZERO = 5'd15;
  localparam logic [4:0] OP_NOOP      = 5'd16;
  localparam logic [4:0] OP_HALT      = 5'd17;
  localparam logic [4:0] OP_OUTPUT    = 5'd18;
  localparam logic [4:0] OP_CHECKMEM  = 5'd19;
  localparam logic [4:0] OP_UNKNOWN   = 5'd20;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_READ,
    UOP_CAPT,
    UOP_SH_INIT,
    UOP_SH_RD,
    UOP_SH_WR,
    UOP_MUL,
    UOP_DIV_INIT,
    UOP_DIV,
    UOP_FINISH
  } uop_e;

  typedef struct packed {
    logic rd_need;
    logic shift;
    logic mul;
    logic div;
    logic div_zero;
    logic sh_done;
    logic mul_last;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/avm_ram.sv -----
`default_nettype none
module avm_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/avm_ctrl.sv -----
`default_nettype none
module avm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire avm_pkg::sts_t sts_i,
  output avm_pkg::uop_e      uop_o,
  output logic               busy_o
);
  import avm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CAPT = 3'd2;
  localparam logic [2:0] S_DCHK = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_SHR  = 3'd6;
  localparam logic [2:0] S_SHW  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    uop_o   = UOP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          uop_o   = UOP_LOAD;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.rd_need) begin
          uop_o   = UOP_READ;
          state_d = S_CAPT;
        end else if (sts_i.shift) begin
          uop_o   = UOP_SH_INIT;
          state_d = S_SHR;
        end else if (sts_i.mul) begin
          state_d = S_MUL;
        end else if (sts_i.div) begin
          state_d = S_DCHK;
        end else begin
          uop_o   = UOP_FINISH;
          state_d = S_IDLE;
        end
      end
      S_CAPT: begin
        uop_o = UOP_CAPT;
        if (sts_i.mul) begin
          state_d = S_MUL;
        end else if (sts_i.div) begin
          state_d = S_DCHK;
        end else begin
          state_d = S_SHW;
        end
      end
      S_DCHK: begin
        if (sts_i.div_zero) begin
          uop_o   = UOP_FINISH;
          state_d = S_IDLE;
        end else begin
          uop_o   = UOP_DIV_INIT;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        uop_o = UOP_DIV;
        if (sts_i.div_last) begin
          state_d = S_SHW;
        end
      end
      S_MUL: begin
        uop_o = UOP_MUL;
        if (sts_i.mul_last) begin
          state_d = S_SHW;
        end
      end
      S_SHR: begin
        if (sts_i.sh_done) begin
          uop_o   = UOP_FINISH;
          state_d = S_IDLE;
        end else begin
          uop_o   = UOP_SH_RD;
          state_d = S_SHW;
        end
      end
      S_SHW: begin
        // shift write, or finish after a memory read, multiply or divide
        if (sts_i.shift) begin
          uop_o   = UOP_SH_WR;
          state_d = S_SHR;
        end else begin
          uop_o   = UOP_FINISH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- hdl/avm_dpath.sv -----
`default_nettype none
module avm_dpath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire avm_pkg::uop_e                          uop_i,
  input  wire logic [1:0]                             cmd_i,
  input  wire logic [4:0]                             opcode_i,
  input  wire logic signed [avm_pkg::ARG_W-1:0]       argument_i,
  input  wire logic signed [avm_pkg::DATA_W-1:0]      data_word_i,
  output avm_pkg::sts_t                               sts_o,
  output logic                                        done_o,
  output logic signed [avm_pkg::ARG_W-1:0]            jump_offset_o,
  output logic [1:0]                                  run_status_o,
  output logic                                        out_valid_o,
  output logic signed [avm_pkg::DATA_W-1:0]           out_value_o,
  output logic [avm_pkg::LEN_W-1:0]                   mem_length_o
);
  import avm_pkg::*;

  logic [1:0]        cmd_q;
  logic [4:0]        op_q;
  logic [ARG_W-1:0]  arg_q;
  logic [DATA_W-1:0] word_q;
  logic [DATA_W-1:0] operand_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [DATA_W-1:0] acc_q, acc_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [1:0]        stat_q, stat_d;
  logic [ARG_W-1:0]  jump_q, jump_d;
  logic              ov_q, ov_d;
  logic [DATA_W-1:0] oval_q, oval_d;
  logic              done_q;

  logic [2*HALF_W-1:0] prod_q;
  logic [DATA_W-1:0]   macc_q;
  logic [DATA_W-1:0]   rem_q, quo_q, dvs_q;
  logic                neg_q;

  logic              run, bad, idx_ok, ins_ok, chk_fail, is_erase, is_div;
  logic              ok;
  logic [CNT_W-1:0]  src;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [DATA_W:0]   rem_sh, diff;
  logic [DATA_W-1:0] div_res, rdata;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata;

  assign run      = (cmd_q == CMD_EXEC) && (stat_q == ST_RUN);
  assign idx_ok   = !arg_q[ARG_W-1] &&
                    (arg_q[ARG_W-2:0] < (ARG_W-1)'(len_q));
  assign ins_ok   = !arg_q[ARG_W-1] &&
                    (arg_q[ARG_W-2:0] <= (ARG_W-1)'(len_q)) &&
                    (len_q < LEN_W'(MEM_DEPTH));
  assign chk_fail = !arg_q[ARG_W-1] &&
                    (arg_q[ARG_W-2:0] > (ARG_W-1)'(len_q));
  assign is_erase = (op_q == OP_ERASE);
  assign is_div   = (op_q == OP_DIVCONST) || (op_q == OP_DIVMEM);

  always_comb begin
    case (op_q)
      OP_AT, OP_SET, OP_ERASE, OP_ADDMEM, OP_SUBMEM, OP_MULMEM, OP_DIVMEM:
        bad = !idx_ok;
      OP_INSERT:
        bad = !ins_ok;
      OP_JUMPREL, OP_JUMPZERO, OP_JUMPNZERO:
        bad = (arg_q == '0);
      OP_CHECKMEM:
        bad = chk_fail;
      default:
        bad = 1'b0;
    endcase
  end

  assign ok = run && !bad;

  assign sts_o.rd_need  = ok && ((op_q == OP_AT) || (op_q == OP_ADDMEM) ||
                                 (op_q == OP_SUBMEM) || (op_q == OP_MULMEM) ||
                                 (op_q == OP_DIVMEM));
  assign sts_o.shift    = ok && (is_erase || (op_q == OP_INSERT));
  assign sts_o.mul      = ok && ((op_q == OP_MULCONST) || (op_q == OP_MULMEM));
  assign sts_o.div      = ok && is_div;
  assign sts_o.div_zero = (operand_q == '0);
  assign sts_o.sh_done  = is_erase ?
                          ((CNT_W+1)'(cnt_q) + (CNT_W+1)'(1) >= (CNT_W+1)'(len_q)) :
                          (cnt_q <= arg_q[CNT_W-1:0]);
  assign sts_o.mul_last = (cnt_q == MUL_LAST);
  assign sts_o.div_last = (cnt_q == DIV_LAST);

  // erase pulls from above, insert pushes from below
  assign src = is_erase ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mul_a = acc_q[HALF_W-1:0];      mul_b = operand_q[HALF_W-1:0];      end
      2'd1:    begin mul_a = acc_q[HALF_W-1:0];      mul_b = operand_q[DATA_W-1:HALF_W]; end
      default: begin mul_a = acc_q[DATA_W-1:HALF_W]; mul_b = operand_q[HALF_W-1:0];      end
    endcase
  end

  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, dvs_q};
  assign div_res = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

  assign ram_re    = (uop_i == UOP_READ) || (uop_i == UOP_SH_RD);
  assign ram_raddr = (uop_i == UOP_READ) ? arg_q[AW-1:0] : src[AW-1:0];

  always_comb begin
    acc_d     = acc_q;
    len_d     = len_q;
    stat_d    = stat_q;
    jump_d    = '0;
    ov_d      = 1'b0;
    oval_d    = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = rdata;
    if (uop_i == UOP_SH_WR) begin
      ram_we = 1'b1;
    end else if (uop_i == UOP_FINISH) begin
      case (cmd_q)
        CMD_RESET: begin
          acc_d  = '0;
          len_d  = '0;
          stat_d = ST_RUN;
        end
        CMD_APPEND: begin
          if (len_q < LEN_W'(MEM_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = len_q[AW-1:0];
            ram_wdata = word_q;
            len_d     = len_q + LEN_W'(1);
          end else begin
            stat_d = ST_ERR;
          end
        end
        CMD_EXEC: begin
          if (run) begin
            if (bad || (is_div && (operand_q == '0))) begin
              stat_d = ST_ERR;
            end else begin
              jump_d = ARG_W'(1);
              case (op_q)
                OP_CLEAR:    acc_d = '0;
                OP_AT:       acc_d = operand_q;
                OP_SET: begin
                  ram_we    = 1'b1;
                  ram_waddr = arg_q[AW-1:0];
                  ram_wdata = acc_q;
                end
                OP_INSERT: begin
                  ram_we    = 1'b1;
                  ram_waddr = arg_q[AW-1:0];
                  ram_wdata = acc_q;
                  len_d     = len_q + LEN_W'(1);
                end
                OP_ERASE:    len_d = len_q - LEN_W'(1);
                OP_ADDCONST, OP_ADDMEM: acc_d = acc_q + operand_q;
                OP_SUBCONST, OP_SUBMEM: acc_d = acc_q - operand_q;
                OP_MULCONST, OP_MULMEM: acc_d = macc_q;
                OP_DIVCONST, OP_DIVMEM: acc_d = div_res;
                OP_JUMPREL:  jump_d = arg_q;
                OP_JUMPZERO: jump_d = (acc_q == '0) ? arg_q : ARG_W'(1);
                OP_JUMPNZERO: jump_d = (acc_q != '0) ? arg_q : ARG_W'(1);
                OP_HALT:     stat_d = ST_HALT;
                OP_OUTPUT: begin
                  ov_d   = 1'b1;
                  oval_d = acc_q;
                end
                OP_UNKNOWN:  stat_d = ST_UNK;
                default:     jump_d = ARG_W'(1);
              endcase
            end
          end
        end
        default: begin
          stat_d = stat_q;
        end
      endcase
    end
  end

  avm_ram #(
    .Width(DATA_W),
    .Depth(MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      len_q  <= '0;
      stat_q <= ST_RUN;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      len_q  <= len_d;
      stat_q <= stat_d;
      done_q <= (uop_i == UOP_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    jump_q <= jump_d;
    ov_q   <= ov_d;
    oval_q <= oval_d;
    case (uop_i)
      UOP_LOAD: begin
        cmd_q     <= cmd_i;
        op_q      <= opcode_i;
        arg_q     <= argument_i;
        word_q    <= data_word_i;
        operand_q <= {{(DATA_W-ARG_W){argument_i[ARG_W-1]}}, argument_i};
        cnt_q     <= '0;
      end
      UOP_CAPT: begin
        operand_q <= rdata;
        cnt_q     <= '0;
      end
      UOP_SH_INIT: begin
        cnt_q <= is_erase ? arg_q[CNT_W-1:0] : len_q;
      end
      UOP_SH_WR: begin
        cnt_q <= src;
      end
      UOP_MUL: begin
        // one 32x32 product per step, accumulate the previous one
        prod_q <= mul_a * mul_b;
        if (cnt_q == CNT_W'(1)) begin
          macc_q <= prod_q;
        end else if (cnt_q != '0) begin
          macc_q <= macc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      UOP_DIV_INIT: begin
        rem_q <= '0;
        quo_q <= acc_q[DATA_W-1] ? (DATA_W'(0) - acc_q) : acc_q;
        dvs_q <= operand_q[DATA_W-1] ? (DATA_W'(0) - operand_q) : operand_q;
        neg_q <= acc_q[DATA_W-1] ^ operand_q[DATA_W-1];
        cnt_q <= '0;
      end
      UOP_DIV: begin
        if (!diff[DATA_W]) begin
          rem_q <= diff[DATA_W-1:0];
        end else begin
          rem_q <= rem_sh[DATA_W-1:0];
        end
        quo_q <= {quo_q[DATA_W-2:0], !diff[DATA_W]};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign done_o        = done_q;
  assign jump_offset_o = jump_q;
  assign run_status_o  = stat_q;
  assign out_valid_o   = ov_q;
  assign out_value_o   = oval_q;
  assign mem_length_o  = len_q;

endmodule
`default_nettype wire

// ----- hdl/accumulator_vm_execute_unit.sv -----
`default_nettype none
// Accumulator machine execute unit.
// Issue an item by raising start_i with cmd_i, opcode_i, argument_i and
// data_word_i; it is taken at the edge where start_i is high and busy_o is
// low. busy_o stays high while the item is worked on.
// Every item yields one result, shown for exactly one cycle with done_o
// high: jump_offset_o, run_status_o, out_valid_o, out_value_o and
// mem_length_o. The receiver cannot stall; it must take the result then.
// Work done for each kind of item before done_o:
//   simple instructions, append and reset: decode, then finish
//   memory-operand instructions: a data memory read comes first
//   multiply: four steps of one shared 32x32 multiplier
//   divide: one quotient bit per cycle; a zero divisor finishes without dividing
//   insert and erase: one read and one write per moved word, one word at a time,
//   through the one read port and one write port of the data memory.
// A new item can be issued in the cycle done_o is high.
// Reset clears the accumulator, the memory length and the status to
// running; memory contents need no clearing since the length gates reads.
module accumulator_vm_execute_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic [4:0]                          opcode_i,
  input  wire logic signed [avm_pkg::ARG_W-1:0]    argument_i,
  input  wire logic signed [avm_pkg::DATA_W-1:0]   data_word_i,
  output logic                                     done_o,
  output logic signed [avm_pkg::ARG_W-1:0]         jump_offset_o,
  output logic [1:0]                               run_status_o,
  output logic                                     out_valid_o,
  output logic signed [avm_pkg::DATA_W-1:0]        out_value_o,
  output logic [avm_pkg::LEN_W-1:0]                mem_length_o
);
  import avm_pkg::*;

  `include "accumulator_vm_execute_unit_macros.svh"

  uop_e uop;
  sts_t sts;

  avm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .uop_o  (uop),
    .busy_o (busy_o)
  );

  avm_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .uop_i        (uop),
    .cmd_i        (cmd_i),
    .opcode_i     (opcode_i),
    .argument_i   (argument_i),
    .data_word_i  (data_word_i),
    .sts_o        (sts),
    .done_o       (done_o),
    .jump_offset_o(jump_offset_o),
    .run_status_o (run_status_o),
    .out_valid_o  (out_valid_o),
    .out_value_o  (out_value_o),
    .mem_length_o (mem_length_o)
  );

  `AVM_ASSERT(a_done_idle, done_o |-> !busy_o)
  `AVM_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `AVM_ASSERT(a_out_with_done, out_valid_o |-> done_o)
  `AVM_ASSERT_NEVER(a_len_range, mem_length_o > LEN_W'(MEM_DEPTH))

endmodule
`default_nettype wire

// ----- dv/tb_accumulator_vm_execute_unit.sv -----
`default_nettype none
module tb_accumulator_vm_execute_unit;
  import avm_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [4:0]  opcode;
    logic [31:0] argument;
    logic [63:0] data_word;
  } item_t;

  typedef struct {
    logic [31:0] jump_offset;
    logic [1:0]  run_status;
    logic        out_valid;
    logic [63:0] out_value;
    logic [6:0]  mem_length;
  } result_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] cmd_i = '0;
  logic [4:0] opcode_i = '0;
  logic signed [ARG_W-1:0] argument_i = '0;
  logic signed [DATA_W-1:0] data_word_i = '0;
  logic busy_o, done_o, out_valid_o;
  logic signed [ARG_W-1:0] jump_offset_o;
  logic [1:0] run_status_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic [LEN_W-1:0] mem_length_o;

  accumulator_vm_execute_unit dut (.*);

  always #5 clk_i = ~clk_i;

  item_t pending_items[$];
  result_t expected_results[$];
  int error_count = 0;

  // predictor state
  logic [63:0] vm_acc;
  logic [63:0] vm_mem[MEM_DEPTH];
  int unsigned vm_len;
  logic [1:0] vm_status;
  // mirror of the length as the generator sees it, used to keep indices in range
  int unsigned gen_len;

  function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic result_t execute_item(item_t it);
    result_t r;
    logic signed [63:0] arg;
    logic [63:0] arg64;
    bit idx_ok;
    int unsigned ix;
    logic [31:0] jump;
    arg = {{32{it.argument[31]}}, it.argument};
    arg64 = arg;
    idx_ok = arg >= 0 && arg < vm_len;
    ix = idx_ok ? arg : 0;
    jump = 0;
    r.out_valid = 0;
    r.out_value = 0;
    if (it.cmd == CMD_RESET) begin
      vm_acc = 0; vm_len = 0; vm_status = ST_RUN;
    end else if (it.cmd == CMD_APPEND) begin
      if (vm_len < MEM_DEPTH) begin
        vm_mem[vm_len] = it.data_word;
        vm_len++;
      end else vm_status = ST_ERR;
    end else if (it.cmd == CMD_EXEC && vm_status == ST_RUN) begin
      jump = 1;
      case (it.opcode)
        OP_CLEAR: vm_acc = 0;
        OP_AT, OP_SET, OP_ERASE, OP_ADDMEM, OP_SUBMEM, OP_MULMEM, OP_DIVMEM:
          if (!idx_ok) begin
            vm_status = ST_ERR; jump = 0;
          end else case (it.opcode)
            OP_AT: vm_acc = vm_mem[ix];
            OP_SET: vm_mem[ix] = vm_acc;
            OP_ERASE: begin
              for (int k = ix; k + 1 < vm_len; k++) vm_mem[k] = vm_mem[k+1];
              vm_len--;
            end
            OP_ADDMEM: vm_acc += vm_mem[ix];
            OP_SUBMEM: vm_acc -= vm_mem[ix];
            OP_MULMEM: vm_acc *= vm_mem[ix];
            default:
              if (vm_mem[ix] == 0) begin
                vm_status = ST_ERR; jump = 0;
              end else vm_acc = signed_quotient(vm_acc, vm_mem[ix]);
          endcase
        OP_INSERT:
          if (arg < 0 || arg > vm_len || vm_len >= MEM_DEPTH) begin
            vm_status = ST_ERR; jump = 0;
          end else begin
            for (int k = vm_len; k > arg; k--) vm_mem[k] = vm_mem[k-1];
            vm_mem[arg] = vm_acc;
            vm_len++;
          end
        OP_ADDCONST: vm_acc += arg64;
        OP_SUBCONST: vm_acc -= arg64;
        OP_MULCONST: vm_acc *= arg64;
        OP_DIVCONST:
          if (arg64 == 0) begin
            vm_status = ST_ERR; jump = 0;
          end else vm_acc = signed_quotient(vm_acc, arg64);
        OP_JUMPREL, OP_JUMPZERO, OP_JUMPNZERO:
          if (arg == 0) begin
            vm_status = ST_ERR; jump = 0;
          end else if (it.opcode == OP_JUMPREL) jump = it.argument;
          else if (it.opcode == OP_JUMPZERO) jump = (vm_acc == 0) ? it.argument : 1;
          else jump = (vm_acc != 0) ? it.argument : 1;
        OP_HALT: vm_status = ST_HALT;
        OP_OUTPUT: begin
          r.out_valid = 1; r.out_value = vm_acc;
        end
        OP_CHECKMEM:
          if (signed'({57'd0, vm_len[6:0]}) < arg) begin
            vm_status = ST_ERR; jump = 0;
          end
        OP_UNKNOWN: vm_status = ST_UNK;
        default: ;
      endcase
    end
    r.jump_offset = jump;
    r.run_status = vm_status;
    r.mem_length = vm_len[6:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      3: return -($urandom_range(1, 5));
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'hffff_ffff_ffff_ffff;
      2: return 64'd0;
      3: return {$urandom, $urandom};
      default: return $urandom_range(0, 50) - 25;
    endcase
  endfunction

  // queue an item; gen_random_item tracks length so most indices land in range
  task automatic add_item(logic [1:0] c, logic [4:0] op, logic [31:0] a, logic [63:0] w);
    item_t it;
    it.cmd = c; it.opcode = op; it.argument = a; it.data_word = w;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic add_exec(logic [4:0] op, logic [31:0] a);
    add_item(CMD_EXEC, op, a, {$urandom, $urandom});
  endtask

  // report a field mismatch
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp_v);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, exp_v, $realtime);
    error_count++;
  endtask

  // driver
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.insert(expected_results.size(),
          execute_item('{cmd_i, opcode_i, argument_i, data_word_i}));
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      end
      if (start_i && busy_o) begin
        // hold
      end else if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start_i <= 1'b0;
        cmd_i <= 2'($urandom); opcode_i <= 5'($urandom);
        argument_i <= $urandom; data_word_i <= {$urandom, $urandom};
      end else begin
        item_t it;
        it = pending_items.pop_front();
        start_i <= 1'b1;
        cmd_i <= it.cmd; opcode_i <= it.opcode;
        argument_i <= it.argument; data_word_i <= it.data_word;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (jump_offset_o !== e.jump_offset)
          report_mismatch("jump_offset", jump_offset_o, e.jump_offset);
        if (run_status_o !== e.run_status)
          report_mismatch("run_status", run_status_o, e.run_status);
        if (out_valid_o !== e.out_valid)
          report_mismatch("out_valid", out_valid_o, e.out_valid);
        if (out_value_o !== e.out_value)
          report_mismatch("out_value", out_value_o, e.out_value);
        if (mem_length_o !== e.mem_length)
          report_mismatch("mem_length", mem_length_o, e.mem_length);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // generator model: random instruction, indices mostly in range
  function automatic logic [31:0] pick_index(bit allow_bad);
    if (allow_bad && $urandom_range(0, 7) == 0) return rand_arg();
    if (gen_len == 0) return $urandom_range(0, 3);
    return $urandom_range(0, gen_len - 1);
  endfunction

  task automatic gen_random_item();
    int sel;
    logic [4:0] op;
    logic [31:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      add_item(CMD_RESET, 5'($urandom), $urandom, {$urandom, $urandom});
      gen_len = 0;
    end else if (sel < 5) begin
      add_item(CMD_NONE, 5'($urandom), $urandom, {$urandom, $urandom});
    end else if (sel < 20) begin
      add_item(CMD_APPEND, 5'($urandom), $urandom, rand_word());
      if (gen_len < MEM_DEPTH) gen_len++;
    end else begin
      op = ($urandom_range(0, 20) == 0) ? 5'($urandom_range(21, 31))
                                         : 5'($urandom_range(0, 19));
      if ($urandom_range(0, 60) == 0) op = OP_UNKNOWN;
      if (op == OP_HALT && $urandom_range(0, 3) != 0) op = OP_OUTPUT;
      case (op)
        OP_AT, OP_SET, OP_ERASE, OP_ADDMEM, OP_SUBMEM, OP_MULMEM, OP_DIVMEM:
          a = pick_index(1);
        OP_INSERT: a = ($urandom_range(0, 7) == 0) ? rand_arg() : $urandom_range(0, gen_len);
        OP_CHECKMEM: a = ($urandom_range(0, 3) == 0) ? rand_arg() : $urandom_range(0, gen_len);
        OP_DIVCONST: a = ($urandom_range(0, 15) == 0) ? 0 : rand_arg();
        default: a = rand_arg();
      endcase
      // conservative length tracking: successful erase shrinks, insert grows
      if (op == OP_ERASE && a < gen_len) begin
        add_exec(op, a); gen_len--;
      end else if (op == OP_INSERT) begin
        // a failed insert changes nothing
        add_exec(op, a);
        if (a <= gen_len && gen_len < MEM_DEPTH) gen_len++;
      end else add_exec(op, a);
    end
  endtask

  initial begin
    gen_len = 0;
    vm_acc = 0; vm_len = 0; vm_status = ST_RUN;
    // directed part
    add_exec(OP_AT, 0);                       // bad index on empty memory
    add_exec(OP_NOOP, 0);                     // ignored while errored
    add_item(CMD_APPEND, 0, 0, 64'h8000_0000_0000_0000);  // append in any status
    add_item(CMD_RESET, 0, 0, 0);
    add_item(CMD_APPEND, 0, 0, 64'hffff_ffff_ffff_ffff);
    add_item(CMD_APPEND, 0, 0, 64'h7fff_ffff_ffff_ffff);
    add_item(CMD_APPEND, 0, 0, 0);
    add_exec(OP_ADDCONST, 32'h8000_0000);
    add_exec(OP_MULCONST, 32'h7fff_ffff);
    add_exec(OP_SUBCONST, 32'hffff_ffff);
    add_exec(OP_OUTPUT, 0);
    add_exec(OP_DIVMEM, 0);                   // divide by -1
    add_exec(OP_MULMEM, 1);
    add_exec(OP_INSERT, 3);
    add_exec(OP_ERASE, 0);
    add_exec(OP_SUBMEM, 1);
    add_exec(OP_SET, 2);
    add_exec(OP_JUMPZERO, 32'h8000_0000);
    add_exec(OP_JUMPNZERO, 32'h7fff_ffff);
    add_exec(OP_JUMPREL, 32'hffff_fffb);
    add_exec(OP_CHECKMEM, 3);
    add_exec(31, 0);                          // unused opcode acts as no-op
    add_exec(OP_DIVMEM, 1);                   // zero divisor
    add_item(CMD_NONE, 0, 0, 0);
    gen_len = 3;
    add_item(CMD_RESET, 0, 0, 0);
    gen_len = 0;
    // fill to full and overflow
    for (int k = 0; k < MEM_DEPTH + 1; k++) add_item(CMD_APPEND, 0, 0, rand_word());
    add_item(CMD_RESET, 0, 0, 0);
    add_exec(OP_UNKNOWN, 0);
    add_exec(OP_HALT, 0);
    add_item(CMD_RESET, 0, 0, 0);
    add_exec(OP_HALT, 0);
    add_item(CMD_RESET, 0, 0, 0);
    add_exec(OP_JUMPREL, 0);                  // zero jump
    add_item(CMD_RESET, 0, 0, 0);
    add_exec(OP_DIVCONST, 0);
    add_item(CMD_RESET, 0, 0, 0);
    gen_len = 0;
    // random part: mostly running sequences started from a fresh reset
    for (int n = 0; n < 800; n++) gen_random_item();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (start_i || expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
